@@ design/rsq_pkg.sv @@
// Shared constants, types and helper functions of the response slot queue.
package rsq_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_DEPTH = 4;

   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int HEAD_W  = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int CNT_W   = $clog2(SLOT_DEPTH + 1);
   localparam int ENTRIES = SLOT_COUNT * SLOT_DEPTH;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SCAN_W  = $clog2(SLOT_COUNT + 1);

   localparam logic [31:0] ORDER_MAX  = 32'hFFFF_FFFF;
   localparam logic [7:0]  RES_MAX    = 8'd255;
   localparam logic [7:0]  CHECK_SEED = 8'h01;
   localparam logic [10:0] TARGET_RST = 11'd1;

   localparam logic [2:0] OP_RECEIVE    = 3'd0;
   localparam logic [2:0] OP_POP_CMD    = 3'd1;
   localparam logic [2:0] OP_POP_OLDEST = 3'd2;
   localparam logic [2:0] OP_RESERVE    = 3'd3;
   localparam logic [2:0] OP_UNRESERVE  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_REJECT  = 2'd2;
   localparam logic [1:0] ST_NO_SLOT = 2'd3;

   typedef struct packed {
      logic idle;
      logic capture;
      logic decode;
      logic scan;
      logic scan_end;
      logic store;
      logic pop_finish;
      logic res_finish;
      logic resp_load;
   } rsq_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       frame_ok;
      logic       hit;
      logic       free;
      logic       pop_ok;
      logic       scan_done;
      logic       pick_ok;
      logic       out_free;
   } rsq_stat_type;

   typedef struct packed {
      logic [31:0] order;
      logic [3:0]  len;
      logic [63:0] bytes;
   } rsq_entry_type;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [HEAD_W-1:0] pos);
      int a;
      a = int'(slot) * SLOT_DEPTH + int'(pos);
      return ADDR_W'(a);
   endfunction

   function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] pos);
      return (int'(pos) == SLOT_DEPTH - 1) ? '0 : HEAD_W'(int'(pos) + 1);
   endfunction

   function automatic logic [2:0] slot_out(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W+2:0] w;
      w = {3'b000, slot};
      return w[2:0];
   endfunction

endpackage

@@ design/response_slot_queue_core.sv @@
// Top level of the response slot queue: controller and datapath.
//
//   channel  prefix  direction  handshake          payload
//   request  req_    in         valid / stall      operation and frame fields
//   response rsp_    out        valid / stall      status, command, frame, slot
//   csr      csr_    in         write enable only  target identifier
//
// One transaction at a time; the request stall is low only in the idle state.
// Receive into a known or free slot, pop by command and reserve operations
// pass from decode through a store, pop or reservation state to the response
// state; a rejected frame, a pop by command that finds nothing and an unknown
// operation go from decode straight to it. The next request is accepted in the
// cycle after the result is loaded. Receive with eviction and pop oldest scan
// one slot per cycle through the frame store read port, then pass a scan end
// state before the store or pop state.
// Synchronous reset; no clearing pass is needed. A stalled result holds the
// block in its response state until taken, and no new request is accepted.
module response_slot_queue_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [10:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [10:0] req_frame_id,
   input  logic [3:0]  req_frame_length,
   input  logic [63:0] req_frame_data,
   input  logic [7:0]  req_command,
   input  logic        req_skip_reserved,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_command_out,
   output logic [3:0]  rsp_out_length,
   output logic [63:0] rsp_out_data,
   output logic [2:0]  rsp_slot_index,
   output logic        rsp_evicted
);

   rsq_pkg::rsq_cmd_type  cmd;
   rsq_pkg::rsq_stat_type stat;

   rsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   rsq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_operation     (req_operation),
      .req_frame_id      (req_frame_id),
      .req_frame_length  (req_frame_length),
      .req_frame_data    (req_frame_data),
      .req_command       (req_command),
      .req_skip_reserved (req_skip_reserved),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_command_out   (rsp_command_out),
      .rsp_out_length    (rsp_out_length),
      .rsp_out_data      (rsp_out_data),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_evicted       (rsp_evicted)
   );

endmodule

@@ design/rsq_ctrl.sv @@
// Controller state machine that sequences each transaction through the datapath.
module rsq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  rsq_pkg::rsq_stat_type stat,
   output rsq_pkg::rsq_cmd_type  cmd,
   output logic                  req_stall
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DECODE   = 8'b0000_0010,
      S_SCAN     = 8'b0000_0100,
      S_SCAN_END = 8'b0000_1000,
      S_STORE    = 8'b0001_0000,
      S_POP      = 8'b0010_0000,
      S_RES      = 8'b0100_0000,
      S_RESP     = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (stat.op)
               rsq_pkg::OP_RECEIVE: begin
                  if (!stat.frame_ok) state_in = S_RESP;
                  else if (stat.hit || stat.free) state_in = S_STORE;
                  else state_in = S_SCAN;
               end
               rsq_pkg::OP_POP_CMD: begin
                  state_in = stat.pop_ok ? S_POP : S_RESP;
               end
               rsq_pkg::OP_POP_OLDEST: state_in = S_SCAN;
               rsq_pkg::OP_RESERVE, rsq_pkg::OP_UNRESERVE: state_in = S_RES;
               default: state_in = S_RESP;
            endcase
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_SCAN_END;
         end
         S_SCAN_END: begin
            if (!stat.pick_ok) state_in = S_RESP;
            else if (stat.op == rsq_pkg::OP_RECEIVE) state_in = S_STORE;
            else state_in = S_POP;
         end
         S_STORE: state_in = S_RESP;
         S_POP:   state_in = S_RESP;
         S_RES:   state_in = S_RESP;
         S_RESP: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      cmd.idle       = (state_ff == S_IDLE);
      cmd.capture    = (state_ff == S_IDLE) && req_valid;
      cmd.decode     = (state_ff == S_DECODE);
      cmd.scan       = (state_ff == S_SCAN);
      cmd.scan_end   = (state_ff == S_SCAN_END);
      cmd.store      = (state_ff == S_STORE);
      cmd.pop_finish = (state_ff == S_POP);
      cmd.res_finish = (state_ff == S_RES);
      cmd.resp_load  = (state_ff == S_RESP) && stat.out_free;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

@@ design/rsq_datapath.sv @@
// Datapath: slot table, frame store, reservation counters, scan logic and result registers.
module rsq_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [10:0]           csr_write_data,
   input  logic [2:0]            req_operation,
   input  logic [10:0]           req_frame_id,
   input  logic [3:0]            req_frame_length,
   input  logic [63:0]           req_frame_data,
   input  logic [7:0]            req_command,
   input  logic                  req_skip_reserved,
   input  rsq_pkg::rsq_cmd_type  cmd,
   output rsq_pkg::rsq_stat_type stat,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_command_out,
   output logic [3:0]            rsp_out_length,
   output logic [63:0]           rsp_out_data,
   output logic [2:0]            rsp_slot_index,
   output logic                  rsp_evicted
);

   localparam int SC = rsq_pkg::SLOT_COUNT;
   localparam int SW = rsq_pkg::SLOT_W;
   localparam int HW = rsq_pkg::HEAD_W;
   localparam int CW = rsq_pkg::CNT_W;
   localparam int AW = rsq_pkg::ADDR_W;

   // Captured transaction.
   logic [2:0]  op_ff;
   logic [10:0] id_ff;
   logic [3:0]  len_ff;
   logic [63:0] data_ff;
   logic [7:0]  cmdin_ff;
   logic        skip_ff;
   logic [10:0] target_ff;

   // Slot table.
   logic          used_ff  [SC];
   logic [7:0]    scmd_ff  [SC];
   logic [HW-1:0] head_ff  [SC];
   logic [CW-1:0] count_ff [SC];
   logic          used_in  [SC];
   logic [7:0]    scmd_in  [SC];
   logic [HW-1:0] head_in  [SC];
   logic [CW-1:0] count_in [SC];

   logic [31:0]   next_order_ff, next_order_in;
   logic [SW-1:0] sel_ff, sel_in;
   logic          ev_ff, ev_in;

   // Scan trackers.
   logic [rsq_pkg::SCAN_W-1:0] cnt_ff, cnt_in;
   logic          a_found_ff, a_found_in, b_found_ff, b_found_in;
   logic [31:0]   a_best_ff, a_best_in, b_best_ff, b_best_in;
   logic [SW-1:0] a_pick_ff, a_pick_in, b_pick_ff, b_pick_in;

   // Memories.
   rsq_pkg::rsq_entry_type frm_mem_ff [rsq_pkg::ENTRIES];
   rsq_pkg::rsq_entry_type frm_rd_ff;
   rsq_pkg::rsq_entry_type frm_wd;
   logic [AW-1:0]          frm_ra, frm_wa;
   logic                   frm_we;

   logic [7:0]   res_mem_ff [256];
   logic [255:0] res_vld_ff;
   logic [7:0]   res_rd_ff;
   logic [7:0]   res_ra, res_wa, res_wd;
   logic         res_we;

   // Result hold registers.
   logic [1:0]  rs_status_ff, rs_status_in;
   logic [7:0]  rs_cmd_ff, rs_cmd_in;
   logic [3:0]  rs_len_ff, rs_len_in;
   logic [63:0] rs_data_ff, rs_data_in;
   logic [2:0]  rs_slot_ff, rs_slot_in;
   logic        rs_ev_ff, rs_ev_in;

   logic        rsp_valid_ff;

   logic [7:0]    fcmd, key, sum, last_byte;
   logic [2:0]    last_idx;
   logic          frame_ok, hit, free, pop_ok, mode_evict, pick_ok;
   logic [SW-1:0] hit_idx, free_idx, scan_idx, prev_idx, pick;
   logic          base, resv, a_take, b_take;
   logic [31:0]   order;

   assign fcmd = data_ff[7:0];
   assign key  = (op_ff == rsq_pkg::OP_RECEIVE) ? fcmd : cmdin_ff;
   assign mode_evict = (op_ff == rsq_pkg::OP_RECEIVE);

   // Checksum: byte sum plus one over all bytes but the last.
   always_comb begin
      sum = rsq_pkg::CHECK_SEED;
      for (int i = 0; i < 8; i++) begin
         if (i + 1 < int'(len_ff)) sum = sum + data_ff[8*i +: 8];
      end
      last_idx  = len_ff[2:0] - 3'd1;
      last_byte = data_ff[{last_idx, 3'b000} +: 8];
      frame_ok  = (len_ff >= 4'd2) && (len_ff <= 4'd8) && (id_ff == target_ff) &&
                  (sum == last_byte);
   end

   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      free = 1'b0;
      free_idx = '0;
      for (int s = 0; s < SC; s++) begin
         if (!hit && used_ff[s] && scmd_ff[s] == key) begin
            hit = 1'b1;
            hit_idx = SW'(s);
         end
         if (!free && !used_ff[s]) begin
            free = 1'b1;
            free_idx = SW'(s);
         end
      end
      pop_ok = hit && (count_ff[hit_idx] != '0);
   end

   // The scan reads one slot per cycle; its head entry is compared in the next cycle.
   always_comb begin
      scan_idx = (int'(cnt_ff) < SC) ? SW'(cnt_ff) : '0;
      prev_idx = SW'(cnt_ff - 1'b1);
      order    = frm_rd_ff.order;
      resv     = (res_rd_ff != 8'd0);
      base     = cmd.scan && (cnt_ff != '0) && used_ff[prev_idx] &&
                 (count_ff[prev_idx] != '0);
      a_take   = base && !(resv && (mode_evict || skip_ff)) &&
                 ((order < a_best_ff) || (!mode_evict && !a_found_ff));
      b_take   = base && (order < b_best_ff);
      if (mode_evict) begin
         pick    = a_found_ff ? a_pick_ff : b_pick_ff;
         pick_ok = a_found_ff || b_found_ff;
      end else begin
         pick    = a_pick_ff;
         pick_ok = a_found_ff;
      end
   end

   always_comb begin
      cnt_in     = cnt_ff;
      a_found_in = a_found_ff;
      a_best_in  = a_best_ff;
      a_pick_in  = a_pick_ff;
      b_found_in = b_found_ff;
      b_best_in  = b_best_ff;
      b_pick_in  = b_pick_ff;
      if (cmd.decode) begin
         cnt_in     = '0;
         a_found_in = 1'b0;
         a_best_in  = rsq_pkg::ORDER_MAX;
         b_found_in = 1'b0;
         b_best_in  = rsq_pkg::ORDER_MAX;
      end else if (cmd.scan) begin
         cnt_in = cnt_ff + 1'b1;
         if (a_take) begin
            a_found_in = 1'b1;
            a_best_in  = order;
            a_pick_in  = prev_idx;
         end
         if (b_take) begin
            b_found_in = 1'b1;
            b_best_in  = order;
            b_pick_in  = prev_idx;
         end
      end
   end

   // Read addresses for the two memories.
   always_comb begin
      priority if (cmd.scan) begin
         frm_ra = rsq_pkg::slot_addr(scan_idx, head_ff[scan_idx]);
         res_ra = scmd_ff[scan_idx];
      end else if (cmd.scan_end) begin
         frm_ra = rsq_pkg::slot_addr(pick, head_ff[pick]);
         res_ra = scmd_ff[pick];
      end else begin
         frm_ra = rsq_pkg::slot_addr(hit_idx, head_ff[hit_idx]);
         res_ra = cmdin_ff;
      end
   end

   // Slot table updates, frame writes, reservation writes and results.
   always_comb begin
      logic [HW-1:0] h;
      logic [CW-1:0] c;
      logic          ov;
      int            tsum;
      for (int s = 0; s < SC; s++) begin
         used_in[s]  = used_ff[s];
         scmd_in[s]  = scmd_ff[s];
         head_in[s]  = head_ff[s];
         count_in[s] = count_ff[s];
      end
      h = '0;
      c = '0;
      ov = 1'b0;
      tsum = 0;
      next_order_in = next_order_ff;
      sel_in = sel_ff;
      ev_in  = ev_ff;
      frm_we = 1'b0;
      frm_wa = '0;
      frm_wd = '{order: next_order_ff, len: len_ff, bytes: data_ff};
      res_we = 1'b0;
      res_wa = cmdin_ff;
      res_wd = res_rd_ff;
      rs_status_in = rs_status_ff;
      rs_cmd_in    = rs_cmd_ff;
      rs_len_in    = rs_len_ff;
      rs_data_in   = rs_data_ff;
      rs_slot_in   = rs_slot_ff;
      rs_ev_in     = rs_ev_ff;

      if (cmd.decode) begin
         sel_in = hit ? hit_idx : free_idx;
         ev_in  = 1'b0;
         rs_cmd_in  = 8'd0;
         rs_len_in  = 4'd0;
         rs_data_in = 64'd0;
         rs_slot_in = 3'd0;
         rs_ev_in   = 1'b0;
         rs_status_in = rsq_pkg::ST_OK;
         if (op_ff == rsq_pkg::OP_RECEIVE && !frame_ok) rs_status_in = rsq_pkg::ST_REJECT;
         if (op_ff == rsq_pkg::OP_POP_CMD && !pop_ok) rs_status_in = rsq_pkg::ST_EMPTY;
         if (op_ff == rsq_pkg::OP_RECEIVE && frame_ok && !hit && free) begin
            used_in[free_idx]  = 1'b1;
            scmd_in[free_idx]  = fcmd;
            head_in[free_idx]  = '0;
            count_in[free_idx] = '0;
         end
      end

      if (cmd.scan_end) begin
         sel_in = pick;
         if (!pick_ok) begin
            if (mode_evict) begin
               rs_status_in = rsq_pkg::ST_NO_SLOT;
               rs_cmd_in    = fcmd;
            end else begin
               rs_status_in = rsq_pkg::ST_EMPTY;
            end
         end else if (mode_evict) begin
            ev_in = 1'b1;
            used_in[pick]  = 1'b1;
            scmd_in[pick]  = fcmd;
            head_in[pick]  = '0;
            count_in[pick] = '0;
         end
      end

      if (cmd.store) begin
         if (int'(count_ff[sel_ff]) >= rsq_pkg::SLOT_DEPTH) begin
            // A full ring drops its oldest frame.
            h  = rsq_pkg::head_inc(head_ff[sel_ff]);
            c  = CW'(rsq_pkg::SLOT_DEPTH - 1);
            ov = 1'b1;
         end else begin
            h = head_ff[sel_ff];
            c = count_ff[sel_ff];
         end
         tsum = int'(h) + int'(c);
         if (tsum >= rsq_pkg::SLOT_DEPTH) tsum = tsum - rsq_pkg::SLOT_DEPTH;
         frm_we = 1'b1;
         frm_wa = rsq_pkg::slot_addr(sel_ff, HW'(tsum));
         next_order_in = next_order_ff + 32'd1;
         head_in[sel_ff]  = h;
         count_in[sel_ff] = c + 1'b1;
         used_in[sel_ff]  = 1'b1;
         scmd_in[sel_ff]  = fcmd;
         rs_status_in = rsq_pkg::ST_OK;
         rs_cmd_in    = fcmd;
         rs_slot_in   = rsq_pkg::slot_out(sel_ff);
         rs_ev_in     = ev_ff || ov;
      end

      if (cmd.pop_finish) begin
         rs_status_in = rsq_pkg::ST_OK;
         rs_cmd_in    = scmd_ff[sel_ff];
         rs_len_in    = frm_rd_ff.len;
         rs_data_in   = frm_rd_ff.bytes;
         rs_slot_in   = rsq_pkg::slot_out(sel_ff);
         rs_ev_in     = 1'b0;
         res_wa = scmd_ff[sel_ff];
         res_wd = res_rd_ff - 8'd1;
         res_we = (res_rd_ff != 8'd0);
         c = count_ff[sel_ff] - 1'b1;
         if (c == '0) begin
            used_in[sel_ff]  = 1'b0;
            scmd_in[sel_ff]  = 8'd0;
            head_in[sel_ff]  = '0;
            count_in[sel_ff] = '0;
         end else begin
            head_in[sel_ff]  = rsq_pkg::head_inc(head_ff[sel_ff]);
            count_in[sel_ff] = c;
         end
      end

      if (cmd.res_finish) begin
         rs_status_in = rsq_pkg::ST_OK;
         rs_cmd_in    = cmdin_ff;
         res_wa = cmdin_ff;
         if (op_ff == rsq_pkg::OP_RESERVE) begin
            res_wd = res_rd_ff + 8'd1;
            res_we = (res_rd_ff != rsq_pkg::RES_MAX);
         end else begin
            res_wd = res_rd_ff - 8'd1;
            res_we = (res_rd_ff != 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         id_ff    <= req_frame_id;
         len_ff   <= req_frame_length;
         data_ff  <= req_frame_data;
         cmdin_ff <= req_command;
         skip_ff  <= req_skip_reserved;
      end
      sel_ff       <= sel_in;
      ev_ff        <= ev_in;
      a_best_ff    <= a_best_in;
      a_pick_ff    <= a_pick_in;
      b_best_ff    <= b_best_in;
      b_pick_ff    <= b_pick_in;
      rs_status_ff <= rs_status_in;
      rs_cmd_ff    <= rs_cmd_in;
      rs_len_ff    <= rs_len_in;
      rs_data_ff   <= rs_data_in;
      rs_slot_ff   <= rs_slot_in;
      rs_ev_ff     <= rs_ev_in;
      if (cmd.resp_load) begin
         rsp_status      <= rs_status_ff;
         rsp_command_out <= rs_cmd_ff;
         rsp_out_length  <= rs_len_ff;
         rsp_out_data    <= rs_data_ff;
         rsp_slot_index  <= rs_slot_ff;
         rsp_evicted     <= rs_ev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= rsq_pkg::TARGET_RST;
         next_order_ff <= 32'd0;
         cnt_ff        <= '0;
         a_found_ff    <= 1'b0;
         b_found_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         res_vld_ff    <= '0;
         for (int s = 0; s < SC; s++) begin
            used_ff[s]  <= 1'b0;
            scmd_ff[s]  <= 8'd0;
            head_ff[s]  <= '0;
            count_ff[s] <= '0;
         end
      end else begin
         if (csr_write_enable) target_ff <= csr_write_data;
         next_order_ff <= next_order_in;
         cnt_ff        <= cnt_in;
         a_found_ff    <= a_found_in;
         b_found_ff    <= b_found_in;
         rsp_valid_ff  <= cmd.resp_load || (rsp_valid_ff && rsp_stall);
         if (res_we) res_vld_ff[res_wa] <= 1'b1;
         for (int s = 0; s < SC; s++) begin
            used_ff[s]  <= used_in[s];
            scmd_ff[s]  <= scmd_in[s];
            head_ff[s]  <= head_in[s];
            count_ff[s] <= count_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frm_we) frm_mem_ff[frm_wa] <= frm_wd;
      frm_rd_ff <= frm_mem_ff[frm_ra];
   end

   // A counter never written reads as zero.
   always_ff @(posedge clock) begin
      if (res_we) res_mem_ff[res_wa] <= res_wd;
      res_rd_ff <= res_vld_ff[res_ra] ? res_mem_ff[res_ra] : 8'd0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      stat.op        = op_ff;
      stat.frame_ok  = frame_ok;
      stat.hit       = hit;
      stat.free      = free;
      stat.pop_ok    = pop_ok;
      stat.scan_done = (int'(cnt_ff) == SC);
      stat.pick_ok   = pick_ok;
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

`ifndef SYNTH
   for (genvar g = 0; g < SC; g++) begin : g_chk
      assert property (@(posedge clock) disable iff (reset)
         int'(count_ff[g]) <= rsq_pkg::SLOT_DEPTH)
         else $error("slot frame count exceeds ring depth");
      assert property (@(posedge clock) disable iff (reset)
         cmd.idle |-> (used_ff[g] == (count_ff[g] != '0)))
         else $error("slot in use without frames between transactions");
   end
   assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |=> rsp_valid_ff)
      else $error("result load did not raise valid");
   assert property (@(posedge clock) disable iff (reset)
      cmd.store |=> (next_order_ff == $past(next_order_ff) + 32'd1))
      else $error("arrival counter did not advance on store");
`endif

endmodule
